@@ rtl/point_set_membership_search_core_assert.svh @@
// Assertion macros shared by the core's modules.
// Every module that uses them has clk and arst_n in scope.
`ifndef POINT_SET_MEMBERSHIP_SEARCH_CORE_ASSERT_SVH
`define POINT_SET_MEMBERSHIP_SEARCH_CORE_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define PSMS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("point set core: assertion failed");

// ante holds -> cons holds in the next cycle
`define PSMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("point set core: assertion failed");

`endif

@@ rtl/psms_pkg.sv @@
`timescale 1ns / 1ps
package psms_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_W        = 32;
	localparam int KEY_W          = 2 * COORD_W;
	localparam int REQ_W          = 2;

	// request codes; code 3 is unused and changes nothing
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch a new transaction
		logic probe;     // read the entry at the search midpoint
		logic step;      // compare probed entry, narrow the search window
		logic shift;     // move one entry up by one slot
		logic ins_write; // write the key at the insert slot
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;      // table holds MAX_POINTS keys
		logic lo_lt_hi;  // search window not empty
		logic dst_gt_lo; // entries still to move
		logic is_query;  // current transaction is a query
	} stat_t;

endpackage

@@ rtl/psms_ctrl.sv @@
`timescale 1ns / 1ps
`include "point_set_membership_search_core_assert.svh"
module psms_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [psms_pkg::REQ_W-1:0]   req_type,
	input  psms_pkg::stat_t              stat,
	output psms_pkg::cmd_t               cmd,
	output logic                         busy,
	output logic                         done
);
	import psms_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SRCH  = 5'b00010,
		ST_CMP   = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_INS   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					priority if (req_type == REQ_QUERY) begin
						state_d = ST_SRCH;
					end else if (req_type == REQ_INSERT && !stat.full) begin
						state_d = ST_SRCH;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			ST_SRCH: begin
				priority if (stat.lo_lt_hi) begin
					cmd.probe = 1'b1;
					state_d   = ST_CMP;
				end else if (stat.is_query) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = ST_SRCH;
			end
			ST_SHIFT: begin
				if (stat.dst_gt_lo) begin
					cmd.shift = 1'b1;
				end else begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				cmd.ins_write = 1'b1;
				done_d        = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	`PSMS_ASSERT_NEXT(a_clear_done, start && !busy && req_type == REQ_CLEAR, done)
	`PSMS_ASSERT_SAME(a_done_idle, done, state_q == ST_IDLE)
	`PSMS_ASSERT_NEXT(a_cmp_to_srch, state_q == ST_CMP, state_q == ST_SRCH)

endmodule

@@ rtl/psms_dpath.sv @@
`timescale 1ns / 1ps
`include "point_set_membership_search_core_assert.svh"
module psms_dpath #(
	parameter int MAX_POINTS = psms_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  psms_pkg::cmd_t                     cmd,
	input  logic [psms_pkg::REQ_W-1:0]         req_type,
	input  logic signed [psms_pkg::COORD_W-1:0] x_coord,
	input  logic signed [psms_pkg::COORD_W-1:0] y_coord,
	output psms_pkg::stat_t                    stat,
	output logic                               found,
	output logic                               table_full
);
	import psms_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [KEY_W-1:0] mem [MAX_POINTS];

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] rd_data_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    lo_q, hi_q, dst_q;
	logic [CW-1:0]    mid, dst_m1;
	logic [AW-1:0]    rd_addr, waddr_q, wa;
	logic [KEY_W-1:0] wd;
	logic             rd_en, we;
	logic             wr_pend_q;
	logic             found_q, full_q, is_query_q;
	logic             le_key, eq_key;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign dst_m1 = dst_q - CW'(1);
	assign le_key = (rd_data_q <= key_q);
	assign eq_key = (rd_data_q == key_q);

	// read port: search probe or shift source
	assign rd_en   = cmd.probe | cmd.shift;
	assign rd_addr = cmd.shift ? dst_m1[AW-1:0] : mid[AW-1:0];

	// write port: pending shift write has the slot, the key write never overlaps it
	assign we = wr_pend_q | cmd.ins_write;
	assign wa = wr_pend_q ? waddr_q : lo_q[AW-1:0];
	assign wd = wr_pend_q ? rd_data_q : key_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= {x_coord, y_coord};
			lo_q  <= '0;
			hi_q  <= count_q;
			dst_q <= count_q;
		end else if (cmd.step) begin
			if (le_key) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end else if (cmd.shift) begin
			dst_q   <= dst_m1;
			waddr_q <= dst_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			wr_pend_q  <= 1'b0;
			found_q    <= 1'b0;
			full_q     <= 1'b0;
			is_query_q <= 1'b0;
		end else begin
			wr_pend_q <= cmd.shift;
			if (cmd.load) begin
				found_q    <= 1'b0;
				full_q     <= (req_type == REQ_INSERT) && stat.full;
				is_query_q <= (req_type == REQ_QUERY);
				if (req_type == REQ_CLEAR) begin
					count_q <= '0;
				end
			end else if (cmd.step) begin
				found_q <= found_q | (is_query_q & eq_key);
			end else if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign stat.full      = (count_q == CW'(MAX_POINTS));
	assign stat.lo_lt_hi  = (lo_q < hi_q);
	assign stat.dst_gt_lo = (dst_q > lo_q);
	assign stat.is_query  = is_query_q;

	assign found      = found_q;
	assign table_full = full_q;

	`PSMS_ASSERT_SAME(a_count_range, 1'b1, count_q <= CW'(MAX_POINTS))
	`PSMS_ASSERT_SAME(a_one_write, 1'b1, !(wr_pend_q && cmd.ins_write))
	`PSMS_ASSERT_SAME(a_flags_excl, 1'b1, !(found_q && full_q))

endmodule

@@ rtl/point_set_membership_search_core.sv @@
`timescale 1ns / 1ps
// Point set membership core: holds up to MAX_POINTS 2-D points as 64-bit keys
// ({x, y} bit patterns) in ascending order in an on-chip memory.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low; req_type selects clear (0), insert (1) or query (2); code 3 is a no-op.
// Result channel: exactly one result per transaction, shown for one cycle with
// done high. found is set for a query hit, table_full for an insert dropped
// because the table is full. The receiver cannot stall; it must take done.
// Sequencing from the accept edge to done:
//   clear, no-op, insert into full table: done is registered; busy never rises.
//   query: P probes of the binary search, P <= ceil(log2(count+1)); each probe
//     reads the memory in the search state, then compares in the compare state.
//   insert: search, then M = keys above the insert slot, moved one per cycle:
//     each cycle reads one entry while writing back the one read before it.
// busy drops on the cycle done is shown, so the next transaction may be
// taken in that same cycle.
// Reset clears the key count and control state; the key memory is not
// cleared and only entries below the count are ever read.
module point_set_membership_search_core #(
	parameter int MAX_POINTS = psms_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [psms_pkg::REQ_W-1:0]          req_type,
	input  logic signed [psms_pkg::COORD_W-1:0] x_coord,
	input  logic signed [psms_pkg::COORD_W-1:0] y_coord,
	output logic                                done,
	output logic                                found,
	output logic                                table_full
);
	import psms_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: search, shift and insert steps
	psms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	// key memory, search window, count and result flags
	psms_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.stat       (stat),
		.found      (found),
		.table_full (table_full)
	);

endmodule
